>>> rtl/core/fqs_pkg.sv
// Package for the FIFO queue with search: item and result structs, kind codes,
// controller states and the control/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package fqs_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [2:0] KIND_ENQ    = 3'd0;
    localparam logic [2:0] KIND_DEQ    = 3'd1;
    localparam logic [2:0] KIND_PEEK   = 3'd2;
    localparam logic [2:0] KIND_SEARCH = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic signed [31:0] front_value;
        logic signed [31:0] rear_value;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic               is_full;
        logic               found;
        logic               error;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_SCAN,
        ST_REPORT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the accepted item, clear result flags
        logic enq_write;   // write the word at tail, bump tail and count
        logic set_err;     // flag the operation as an error
        logic clear;       // return pointers and count to zero
        logic read_head;   // read the head entry, arm the scan pointer
        logic take_front;  // capture the read word as front value
        logic pop;         // advance head, drop count
        logic scan_step;   // compare read word, read the next entry
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] kind;
        logic       empty;
        logic       full;
        logic       match;      // read word equals the search value
        logic       scan_last;  // the word under compare is the last valid one
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/core/fqs_ctrl.sv
// Controller state machine for the FIFO queue with search.
// Depends on fqs_pkg for states, kind codes and the command/status structs.
`default_nettype none

module fqs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire fqs_pkg::t_dp_stat i_stat,
    output fqs_pkg::t_dp_cmd      o_cmd,
    output logic                  o_busy,
    output logic                  o_valid
);

    fqs_pkg::t_state r_state;
    fqs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fqs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            fqs_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = fqs_pkg::ST_EXEC;
                end
            end
            fqs_pkg::ST_EXEC: begin
                n_state = fqs_pkg::ST_REPORT;
                case (i_stat.kind)
                    fqs_pkg::KIND_ENQ: begin
                        if (i_stat.full) begin
                            o_cmd.set_err = 1'b1;
                        end else begin
                            o_cmd.enq_write = 1'b1;
                        end
                    end
                    fqs_pkg::KIND_DEQ, fqs_pkg::KIND_PEEK: begin
                        if (i_stat.empty) begin
                            o_cmd.set_err = 1'b1;
                        end else begin
                            o_cmd.read_head = 1'b1;
                            n_state         = fqs_pkg::ST_FETCH;
                        end
                    end
                    fqs_pkg::KIND_SEARCH: begin
                        if (!i_stat.empty) begin
                            o_cmd.read_head = 1'b1;
                            n_state         = fqs_pkg::ST_SCAN;
                        end
                    end
                    fqs_pkg::KIND_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            fqs_pkg::ST_FETCH: begin
                o_cmd.take_front = 1'b1;
                o_cmd.pop        = (i_stat.kind == fqs_pkg::KIND_DEQ);
                n_state          = fqs_pkg::ST_REPORT;
            end
            fqs_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.match || i_stat.scan_last) begin
                    n_state = fqs_pkg::ST_REPORT;
                end
            end
            fqs_pkg::ST_REPORT: begin
                o_valid = 1'b1;
                n_state = fqs_pkg::ST_IDLE;
            end
            default: begin
                n_state = fqs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/fqs_dp.sv
// Datapath for the FIFO queue with search: entry memory, head/tail pointers,
// count, newest-word copy, scan pointer and result registers. Depends on fqs_pkg.
`default_nettype none

module fqs_dp #(
    parameter int DEPTH      = fqs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire fqs_pkg::t_item   i_item,
    input  wire fqs_pkg::t_dp_cmd i_cmd,
    output fqs_pkg::t_dp_stat     o_stat,
    output fqs_pkg::t_result      o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]         rd_addr;

    logic [2:0]            r_kind;
    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] r_rear_word;
    logic [AW-1:0]         r_head, r_tail, r_scan_ptr;
    logic [CW-1:0]         r_count, r_scan_left;
    logic signed [31:0]    r_front;
    logic                  r_found, r_err;

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
        next_pos = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign rd_addr = i_cmd.read_head ? r_head : r_scan_ptr;

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_write) begin
            r_mem[r_tail] <= r_word;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_item.kind;
            r_word <= DATA_WIDTH'($unsigned(i_item.value));
        end
        if (i_cmd.enq_write) begin
            r_rear_word <= r_word;
        end
        if (i_cmd.read_head) begin
            r_scan_ptr  <= next_pos(r_head);
            r_scan_left <= r_count;
        end else if (i_cmd.scan_step) begin
            r_scan_ptr  <= next_pos(r_scan_ptr);
            r_scan_left <= r_scan_left - 1'b1;
        end
        if (i_cmd.load) begin
            r_front <= '0;
        end else if (i_cmd.take_front) begin
            r_front <= 32'($signed(r_rd_data));
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_found <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_found <= 1'b0;
                r_err   <= 1'b0;
            end
            if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
            if (i_cmd.scan_step && o_stat.match) begin
                r_found <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
            end else if (i_cmd.enq_write) begin
                r_tail  <= next_pos(r_tail);
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop) begin
                r_head  <= next_pos(r_head);
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.match     = (r_rd_data == r_word);
    assign o_stat.scan_last = (r_scan_left == CW'(1));

    assign o_result.front_value = r_front;
    assign o_result.rear_value  = o_stat.empty ? 32'sd0 : 32'($signed(r_rear_word));
    assign o_result.entry_count = 5'(r_count);
    assign o_result.is_empty    = o_stat.empty;
    assign o_result.is_full     = o_stat.full;
    assign o_result.found       = r_found;
    assign o_result.error       = r_err;

endmodule

`default_nettype wire

>>> rtl/core/fifo_queue_with_search.sv
// FIFO queue with search. An accepted item goes through EXEC to REPORT, which
// strobes the result, for enqueue, clear, unused kinds and dequeue, peek or
// search on an empty queue; dequeue and peek pass through FETCH (one registered
// read of the entry memory); search stays in SCAN to a match or the last valid
// entry, one entry compared per cycle; busy falls the cycle after the strobe.
// Synchronous active-low reset empties the queue; the receiver cannot stall.
`default_nettype none

module fifo_queue_with_search #(
    parameter int DEPTH      = fqs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire fqs_pkg::t_item i_cmd,
    output logic                busy,
    output logic                o_valid,
    output fqs_pkg::t_result    o_result
);

    // command and status between the sequencer and the queue datapath
    fqs_pkg::t_dp_cmd  dp_cmd;
    fqs_pkg::t_dp_stat dp_stat;

    // Sequencer: take a transfer when idle, run the operation, strobe the result.
    fqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // Datapath: hold entries, pointers and count; result fields come straight
    // from its registers and are stable during the strobe cycle.
    fqs_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_cmd),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for fifo_queue_with_search: directed table, then random queue traffic.
// Shadow-queue predictor built on fqs_pkg item/result structs and kind codes; needs the RTL only.
`default_nettype none

module tb_top;

    // Kind codes the block treats as no operation
    localparam logic [2:0] KIND_NOP5 = 3'd5;
    localparam logic [2:0] KIND_NOP6 = 3'd6;
    localparam logic [2:0] KIND_NOP7 = 3'd7;

    localparam int QUEUE_DEPTH = fqs_pkg::DEPTH_DEF;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    // Drain wait: covers the longest search, which walks every entry, plus margin
    localparam int DRAIN_CYCLES = QUEUE_DEPTH + 8;

    localparam int PHASE_IDLE [3]  = '{8, 68, 0};
    localparam int PHASE_ITEMS [3] = '{600, 600, 500};

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             start   = 1'b0;
    fqs_pkg::t_item   i_cmd   = '0;
    logic             busy;
    logic             o_valid;
    fqs_pkg::t_result o_result;

    fifo_queue_with_search u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow queue: ring of words, head/tail pointers and occupancy
    // ------------------------------------------------------------------
    logic signed [31:0] shadow_words [QUEUE_DEPTH];
    logic [PTR_W-1:0]   shadow_head  = '0;
    logic [PTR_W-1:0]   shadow_tail  = '0;
    int                 shadow_count = 0;

    fqs_pkg::t_result pending_results[$];
    bit               mismatch_seen = 1'b0;
    int               idle_pct      = 0;
    bit               filling       = 1'b1;

    // Apply one operation to the shadow queue and return the status it reports
    function automatic fqs_pkg::t_result apply_queue_op(fqs_pkg::t_item it);
        fqs_pkg::t_result res;
        logic [PTR_W-1:0] p;
        res = '0;
        case (it.kind)
            fqs_pkg::KIND_ENQ: begin
                // drop the word when full
                if (shadow_count >= QUEUE_DEPTH) begin
                    res.error = 1'b1;
                end else begin
                    shadow_words[shadow_tail] = it.value;
                    shadow_tail++;
                    shadow_count++;
                end
            end
            fqs_pkg::KIND_DEQ, fqs_pkg::KIND_PEEK: begin
                if (shadow_count == 0) begin
                    res.error = 1'b1;
                end else begin
                    res.front_value = shadow_words[shadow_head];
                    // peek leaves the front entry in place
                    if (it.kind == fqs_pkg::KIND_DEQ) begin
                        shadow_head++;
                        shadow_count--;
                    end
                end
            end
            fqs_pkg::KIND_SEARCH: begin
                // only valid entries take part in the compare
                p = shadow_head;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_words[p] == it.value) res.found = 1'b1;
                    p++;
                end
            end
            fqs_pkg::KIND_CLEAR: begin
                shadow_head  = '0;
                shadow_tail  = '0;
                shadow_count = 0;
            end
            default: ;
        endcase
        if (shadow_count != 0) res.rear_value = shadow_words[shadow_tail - 1'b1];
        res.entry_count = 5'(shadow_count);
        res.is_empty    = (shadow_count == 0);
        res.is_full     = (shadow_count >= QUEUE_DEPTH);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Command side: hold start and the item until a transfer, with random
    // gaps ahead of an item. Predict at the transfer edge.
    // ------------------------------------------------------------------
    task automatic send_item(fqs_pkg::t_item it, bit typed, fqs_pkg::t_result want);
        fqs_pkg::t_result predicted;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predicted = apply_queue_op(it);
        // typed-in rows stand in for the prediction; the shadow still advances
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Random traffic: swing between filling and draining so the count
    // sweeps empty to full, and aim most searches at held words.
    task automatic draw_random_item(output fqs_pkg::t_item it);
        int roll;
        int pick;
        int enq_cut;
        int deq_cut;
        int peek_cut;
        int search_cut;
        int clear_cut;
        if (shadow_count >= QUEUE_DEPTH) filling = 1'b0;
        else if (shadow_count == 0) filling = 1'b1;
        else if ($urandom_range(99) < 3) filling = !filling;

        enq_cut    = filling ? 58 : 18;
        deq_cut    = filling ? 70 : 58;
        peek_cut   = filling ? 78 : 68;
        search_cut = filling ? 94 : 90;
        clear_cut  = filling ? 96 : 93;

        roll = $urandom_range(99);
        if (roll < enq_cut)         it.kind = fqs_pkg::KIND_ENQ;
        else if (roll < deq_cut)    it.kind = fqs_pkg::KIND_DEQ;
        else if (roll < peek_cut)   it.kind = fqs_pkg::KIND_PEEK;
        else if (roll < search_cut) it.kind = fqs_pkg::KIND_SEARCH;
        else if (roll < clear_cut)  it.kind = fqs_pkg::KIND_CLEAR;
        else                        it.kind = KIND_NOP5 + 3'($urandom_range(2));

        pick = $urandom_range(9);
        if (it.kind == fqs_pkg::KIND_SEARCH && shadow_count > 0 && pick < 6) begin
            it.value = shadow_words[(shadow_head + $urandom_range(shadow_count - 1))
                                   % QUEUE_DEPTH];
        end else if (pick < 4) begin
            it.value = $urandom;
        end else if (pick < 6) begin
            case ($urandom_range(3))
                0:       it.value = 32'sh7FFF_FFFF;
                1:       it.value = 32'sh8000_0000;
                2:       it.value = '0;
                default: it.value = -32'sd1;
            endcase
        end else begin
            // small values repeat often, so searches hit duplicates
            it.value = $urandom_range(15);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: accept each strobed result and compare with the oldest
    // pending expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        fqs_pkg::t_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no pending expectation");
                mismatch_seen = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (o_result !== want) mismatch_seen = 1'b1;
                if (o_result.front_value !== want.front_value)
                    $error("front_value: expected %0d, got %0d",
                           want.front_value, o_result.front_value);
                if (o_result.rear_value !== want.rear_value)
                    $error("rear_value: expected %0d, got %0d",
                           want.rear_value, o_result.rear_value);
                if (o_result.entry_count !== want.entry_count)
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, o_result.entry_count);
                if (o_result.is_empty !== want.is_empty)
                    $error("is_empty: expected %0b, got %0b",
                           want.is_empty, o_result.is_empty);
                if (o_result.is_full !== want.is_full)
                    $error("is_full: expected %0b, got %0b",
                           want.is_full, o_result.is_full);
                if (o_result.found !== want.found)
                    $error("found: expected %0b, got %0b", want.found, o_result.found);
                if (o_result.error !== want.error)
                    $error("error: expected %0b, got %0b", want.error, o_result.error);
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table: kind, value, repeat count (value steps by one per
    // repeat) and, where obvious, the expected status typed in.
    // ------------------------------------------------------------------
    typedef struct {
        fqs_pkg::t_item   it;
        int               reps;
        bit               typed;
        fqs_pkg::t_result want;
    } t_directed_row;

    t_directed_row directed_rows[$];

    task automatic add_row(logic [2:0] kind, logic signed [31:0] value, int reps);
        t_directed_row row;
        row.it.kind  = kind;
        row.it.value = value;
        row.reps     = reps;
        row.typed    = 1'b0;
        row.want     = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_checked(logic [2:0] kind, logic signed [31:0] value,
                               fqs_pkg::t_result want);
        t_directed_row row;
        row.it.kind  = kind;
        row.it.value = value;
        row.reps     = 1;
        row.typed    = 1'b1;
        row.want     = want;
        directed_rows.push_back(row);
    endtask

    initial begin
        fqs_pkg::t_item it;
        // status fields: front, rear, count, empty, full, found, error
        // empty queue after reset: dequeue and peek flag an error, search misses
        add_checked(fqs_pkg::KIND_DEQ, '0,
                    fqs_pkg::t_result'{'0, '0, 5'd0, 1'b1, 1'b0, 1'b0, 1'b1});
        add_checked(fqs_pkg::KIND_PEEK, '0,
                    fqs_pkg::t_result'{'0, '0, 5'd0, 1'b1, 1'b0, 1'b0, 1'b1});
        add_checked(fqs_pkg::KIND_SEARCH, '0,
                    fqs_pkg::t_result'{'0, '0, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0});
        // value extremes
        add_checked(fqs_pkg::KIND_ENQ, 32'sh7FFF_FFFF,
                    fqs_pkg::t_result'{'0, 32'sh7FFF_FFFF, 5'd1, 1'b0, 1'b0, 1'b0, 1'b0});
        add_checked(fqs_pkg::KIND_ENQ, 32'sh8000_0000,
                    fqs_pkg::t_result'{'0, 32'sh8000_0000, 5'd2, 1'b0, 1'b0, 1'b0, 1'b0});
        add_row(fqs_pkg::KIND_ENQ,    -32'sd1, 1);
        add_row(fqs_pkg::KIND_SEARCH, 32'sh8000_0000, 1);
        add_row(fqs_pkg::KIND_SEARCH, 32'sd12345, 1);
        // peek must not remove the front entry, so the dequeue returns it again
        add_row(fqs_pkg::KIND_PEEK, '0, 1);
        add_checked(fqs_pkg::KIND_DEQ, '0,
                    fqs_pkg::t_result'{32'sh7FFF_FFFF, -32'sd1, 5'd2,
                                       1'b0, 1'b0, 1'b0, 1'b0});
        // unused kind codes
        add_row(KIND_NOP5, 32'sd77, 1);
        add_row(KIND_NOP6, 32'sd77, 1);
        add_row(KIND_NOP7, 32'sd77, 1);
        add_checked(fqs_pkg::KIND_CLEAR, '0,
                    fqs_pkg::t_result'{'0, '0, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0});
        add_checked(fqs_pkg::KIND_DEQ, '0,
                    fqs_pkg::t_result'{'0, '0, 5'd0, 1'b1, 1'b0, 1'b0, 1'b1});
        // fill to the brim, then overflow: the word is dropped
        add_row(fqs_pkg::KIND_ENQ, 32'sh100, QUEUE_DEPTH);
        add_checked(fqs_pkg::KIND_ENQ, 32'sh55AA_55AA,
                    fqs_pkg::t_result'{'0, 32'sh10F, 5'd16, 1'b0, 1'b1, 1'b0, 1'b1});
        add_row(fqs_pkg::KIND_SEARCH, 32'sh10F, 1);
        add_row(fqs_pkg::KIND_SEARCH, 32'sh100, 1);
        add_row(fqs_pkg::KIND_SEARCH, 32'sh55AA_55AA, 1);
        add_row(KIND_NOP7,   '0, 1);
        // drain part way and refill, so the live entries span the wrap point
        add_row(fqs_pkg::KIND_DEQ, '0, 5);
        add_row(fqs_pkg::KIND_ENQ, 32'shAAAA_0000, 5);
        add_row(fqs_pkg::KIND_SEARCH, 32'shAAAA_0004, 1);
        add_row(fqs_pkg::KIND_PEEK, '0, 1);
        add_row(fqs_pkg::KIND_CLEAR, '0, 1);

        // hold reset low before releasing it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = PHASE_IDLE[0];
        foreach (directed_rows[n]) begin
            for (int r = 0; r < directed_rows[n].reps; r++) begin
                it       = directed_rows[n].it;
                it.value = it.value + r;
                send_item(it, directed_rows[n].typed, directed_rows[n].want);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = PHASE_IDLE[phase];
            for (int k = 0; k < PHASE_ITEMS[phase]; k++) begin
                draw_random_item(it);
                send_item(it, 1'b0, '0);
            end
        end
        start <= 1'b0;

        // wait out every pending result, then let a late strobe show up
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!mismatch_seen && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest legal run
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
